// ===== hw/rtl/stsr_pkg.sv =====
// Shared widths, register indexes and reset values for the stick-to-stepper-rate block.
// Used by the channel interfaces, the divide/root unit and the top level.
package stsr_pkg;

    localparam int STICK_W   = 11;  // stick and dial samples, signed
    localparam int CLK_W     = 28;  // timer clock over step rate
    localparam int BAND_W    = 11;
    localparam int MAG_W     = 12;  // doubled stick magnitude, 2..2048 outside the dead band
    localparam int QUO_W     = CLK_W;
    localparam int ROOT_W    = QUO_W / 2;
    localparam int RELOAD_W  = 13;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = CLK_W;

    localparam logic [RELOAD_W-1:0] RELOAD_MAX = {RELOAD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_THR  = 2'd2;

    localparam logic [CLK_W-1:0]          CORE_CLOCK_RST = 28'd168000000;
    localparam logic [BAND_W-1:0]         DEAD_BAND_RST  = 11'd10;
    localparam logic signed [STICK_W-1:0] RELAY_THR_RST  = 11'sd1000;

endpackage

// ===== hw/rtl/stsr_in_if.sv =====
// Input channel: one remote-control frame per request.
// Depends on stsr_pkg for field widths.
interface stsr_in_if;
    import stsr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      enable_frame;
    logic signed [STICK_W-1:0] pick_stick;
    logic signed [STICK_W-1:0] hold_stick;
    logic signed [STICK_W-1:0] pot_stick;
    logic signed [STICK_W-1:0] relay_dial;

    modport source (output valid, enable_frame, pick_stick, hold_stick, pot_stick, relay_dial,
                    input ready);
    modport sink   (input valid, enable_frame, pick_stick, hold_stick, pot_stick, relay_dial,
                    output ready);
endinterface

// ===== hw/rtl/stsr_out_if.sv =====
// Output channel: stepper direction, run and reload for three axes plus the relay level.
// Depends on stsr_pkg for field widths.
interface stsr_out_if;
    import stsr_pkg::*;

    logic                valid;
    logic                ready;
    logic                pick_dir;
    logic                pick_run;
    logic [RELOAD_W-1:0] pick_reload;
    logic                hold_dir;
    logic                hold_run;
    logic [RELOAD_W-1:0] hold_reload;
    logic                pot_dir;
    logic                pot_run;
    logic [RELOAD_W-1:0] pot_reload;
    logic                relay_on;

    modport source (output valid, pick_dir, pick_run, pick_reload, hold_dir, hold_run,
                    hold_reload, pot_dir, pot_run, pot_reload, relay_on,
                    input ready);
    modport sink   (input valid, pick_dir, pick_run, pick_reload, hold_dir, hold_run,
                    hold_reload, pot_dir, pot_run, pot_reload, relay_on,
                    output ready);
endinterface

// ===== hw/rtl/stsr_divsqrt.sv =====
// Bit-serial unit: floor(sqrt(dividend / divisor)), one quotient bit per cycle, then
// one root bit per cycle. Depends on stsr_pkg.
module stsr_divsqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stsr_pkg::QUO_W-1:0]    i_dividend,
    input  logic [stsr_pkg::MAG_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [stsr_pkg::ROOT_W-1:0]   o_root
);
    import stsr_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_DONE} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [QUO_W-1:0]    r_quo;
    logic [MAG_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_divisor;
    logic [ROOT_W+1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;

    logic [MAG_W:0]      div_trial;
    logic [MAG_W:0]      div_diff;
    logic                div_ge;
    logic [ROOT_W+3:0]   sq_trial;
    logic [ROOT_W+3:0]   sq_test;
    logic [ROOT_W+3:0]   sq_diff;
    logic                sq_ge;

    // restoring division step: bring down one dividend bit
    assign div_trial = {r_rem, r_quo[QUO_W-1]};
    assign div_diff  = div_trial - {1'b0, r_divisor};
    assign div_ge    = div_trial >= {1'b0, r_divisor};

    // root step: bring down two radicand bits, try root*4+1
    assign sq_trial = {r_srem, r_quo[QUO_W-1 -: 2]};
    assign sq_test  = {2'b00, r_root, 2'b01};
    assign sq_diff  = sq_trial - sq_test;
    assign sq_ge    = sq_trial >= sq_test;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_quo     <= i_dividend;
                        r_divisor <= i_divisor;
                        r_rem     <= '0;
                        r_cnt     <= DIV_LAST;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_diff[MAG_W-1:0] : div_trial[MAG_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], div_ge};
                    if (r_cnt == '0) begin
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= SQRT_LAST;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? sq_diff[ROOT_W+1:0] : sq_trial[ROOT_W+1:0];
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_root = r_root;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("divsqrt started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divsqrt done held more than one cycle");

    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_done)
        else $error("divsqrt done right after start");

endmodule

// ===== hw/rtl/stick_to_stepper_rate.sv =====
// Top level of the stick-to-stepper-rate block: frame in, stepper timer settings out.
// Depends on stsr_pkg, stsr_in_if, stsr_out_if and stsr_divsqrt.

// A frame request is taken only while the block is idle; the previous result may still sit
// in the output register meanwhile. Axes are handled one after another by one bit-serial
// divide/root unit: an axis inside its dead band ends in S_AXIS; a running axis waits in
// S_WAIT while the unit works out 28 quotient bits, then 14 root bits. A frame with enable
// low goes from accept to S_FINISH, which waits for a free output register. The relay level
// is set at accept for enabled frames. Config is written via i_cfg_we/i_cfg_idx/i_cfg_data.
module stick_to_stepper_rate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [stsr_pkg::CFG_W-1:0]      i_cfg_data,
    stsr_in_if.sink                         i_in,
    stsr_out_if.source                      o_out
);
    import stsr_pkg::*;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

    typedef enum logic [1:0] {S_IDLE, S_AXIS, S_WAIT, S_FINISH} t_state;

    // configuration
    logic [CLK_W-1:0]          r_core_clock;
    logic [BAND_W-1:0]         r_dead_band;
    logic signed [STICK_W-1:0] r_relay_thr;

    // control and axis state
    t_state                    r_state;
    logic [AXIS_W-1:0]         r_axis;
    logic [AXES-1:0]           r_run;
    logic [AXES-1:0]           r_dir;
    logic [RELOAD_W-1:0]       r_reload [AXES];
    logic                      r_relay;
    logic signed [STICK_W-1:0] r_stick [AXES];

    // output register
    logic                      r_out_valid;
    logic [AXES-1:0]           r_o_run;
    logic [AXES-1:0]           r_o_dir;
    logic [RELOAD_W-1:0]       r_o_reload [AXES];
    logic                      r_o_relay;

    logic                      accept;
    logic                      out_free;
    logic signed [MAG_W-1:0]   fr;
    logic signed [MAG_W-1:0]   band;
    logic                      fr_pos;
    logic                      fr_neg;
    logic [MAG_W-1:0]          mag;
    logic                      u_done;
    logic [ROOT_W-1:0]         u_root;
    logic [RELOAD_W-1:0]       sat_reload;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // doubled stick against the dead band
    assign fr     = $signed({r_stick[r_axis], 1'b0});
    assign band   = $signed({1'b0, r_dead_band});
    assign fr_pos = fr > band;
    assign fr_neg = fr < -band;
    assign mag    = fr_neg ? MAG_W'(-fr) : MAG_W'(fr);

    // reload is root minus one, floored at zero and clipped to the counter width
    always_comb begin
        if (u_root == '0) begin
            sat_reload = '0;
        end else if (u_root > ROOT_W'({1'b0, RELOAD_MAX}) + ROOT_W'(1)) begin
            sat_reload = RELOAD_MAX;
        end else begin
            sat_reload = RELOAD_W'(u_root - ROOT_W'(1));
        end
    end

    stsr_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_AXIS && (fr_pos || fr_neg)),
        .i_dividend (r_core_clock),
        .i_divisor  (mag),
        .o_done     (u_done),
        .o_root     (u_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_clock <= CORE_CLOCK_RST;
            r_dead_band  <= DEAD_BAND_RST;
            r_relay_thr  <= RELAY_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORE_CLOCK: r_core_clock <= i_cfg_data[CLK_W-1:0];
                CFG_DEAD_BAND:  r_dead_band  <= i_cfg_data[BAND_W-1:0];
                CFG_RELAY_THR:  r_relay_thr  <= $signed(i_cfg_data[STICK_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_run       <= '0;
            r_dir       <= '0;
            r_reload    <= '{default: '0};
            r_relay     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded in the same cycle
            if (r_out_valid && o_out.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_stick[0] <= i_in.pick_stick;
                        r_stick[1] <= i_in.hold_stick;
                        r_stick[2] <= i_in.pot_stick;
                        r_axis     <= '0;
                        if (i_in.enable_frame) begin
                            r_relay <= i_in.relay_dial > r_relay_thr;
                            r_state <= S_AXIS;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_AXIS: begin
                    if (fr_pos) begin
                        r_dir[r_axis] <= 1'b1;
                    end else if (fr_neg) begin
                        r_dir[r_axis] <= 1'b0;
                    end
                    if (fr_pos || fr_neg) begin
                        r_state <= S_WAIT;
                    end else begin
                        // inside the band: stop, keep direction and reload
                        r_run[r_axis] <= 1'b0;
                        if (r_axis == AXIS_LAST) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end
                end
                S_WAIT: begin
                    if (u_done) begin
                        r_run[r_axis]    <= 1'b1;
                        r_reload[r_axis] <= sat_reload;
                        if (r_axis == AXIS_LAST) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_AXIS;
                        end
                    end
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_o_run     <= r_run;
                        r_o_dir     <= r_dir;
                        r_o_reload  <= r_reload;
                        r_o_relay   <= r_relay;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.pick_dir    = r_o_dir[0];
    assign o_out.pick_run    = r_o_run[0];
    assign o_out.pick_reload = r_o_reload[0];
    assign o_out.hold_dir    = r_o_dir[1];
    assign o_out.hold_run    = r_o_run[1];
    assign o_out.hold_reload = r_o_reload[1];
    assign o_out.pot_dir     = r_o_dir[2];
    assign o_out.pot_run     = r_o_run[2];
    assign o_out.pot_reload  = r_o_reload[2];
    assign o_out.relay_on    = r_o_relay;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("frame request accepted without leaving idle");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> r_state == S_WAIT)
        else $error("root result arrived outside the wait state");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished frame not loaded into the output register");

endmodule
